// ===== rtl/chebyshev_waveshaper_top_assert.svh =====
// Assertion macros shared by the waveshaper RTL, empty for synthesis.
`ifndef CHEBYSHEV_WAVESHAPER_TOP_ASSERT_SVH
`define CHEBYSHEV_WAVESHAPER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CWS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("waveshaper assertion failed");
`define CWS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("waveshaper assertion failed");
`else
`define CWS_ASSERT_IMPL(lbl, ante, cons)
`define CWS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/cws_pkg.sv =====
// Shared constants and types of the Chebyshev waveshaper.
package cws_pkg;

  localparam int DATA_WIDTH  = 24;
  localparam int MAX_TERMS   = 32;
  localparam int IDX_W       = $clog2(MAX_TERMS);
  localparam int IDX_FIELD_W = 5;
  localparam int CFG_W       = 6;
  localparam int FRAC_X      = DATA_WIDTH - 1;
  localparam int FRAC_C      = DATA_WIDTH - 4;

  // Chebyshev values span [-1.0, +1.0], so +1.0 needs one bit more than a sample.
  localparam int T_W    = DATA_WIDTH + 1;
  localparam int PROD_W = DATA_WIDTH + T_W;
  localparam int ACC_W  = PROD_W + IDX_W + 1;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_WRITE  = 1'b1;

  typedef logic signed [DATA_WIDTH-1:0] coef_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    coef_t            data;
  } coef_wr_t;

endpackage

// ===== rtl/cws_in_if.sv =====
// Input channel of the waveshaper: samples and coefficient writes.
interface cws_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 action;
  logic [cws_pkg::IDX_FIELD_W-1:0]      coeff_index;
  logic signed [cws_pkg::DATA_WIDTH-1:0] coeff_value;
  logic signed [cws_pkg::DATA_WIDTH-1:0] sample;

  modport source (output valid, action, coeff_index, coeff_value, sample, input ready);
  modport sink   (input valid, action, coeff_index, coeff_value, sample, output ready);
endinterface

// ===== rtl/cws_out_if.sv =====
// Output channel of the waveshaper: shaped samples with their clip flag.
interface cws_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cws_pkg::DATA_WIDTH-1:0] shaped_sample;
  logic                                 saturated;

  modport source (output valid, shaped_sample, saturated, input ready);
  modport sink   (input valid, shaped_sample, saturated, output ready);
endinterface

// ===== rtl/cws_coef_mem.sv =====
// Coefficient table: synchronous single-port-read memory with per-entry valid bits.
module cws_coef_mem (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cws_pkg::coef_wr_t              wr_i,
  input  logic [cws_pkg::IDX_W-1:0]      rd_addr_i,
  output cws_pkg::coef_t                 rd_data_o
);

  cws_pkg::coef_t                 mem [cws_pkg::MAX_TERMS];
  logic [cws_pkg::MAX_TERMS-1:0]  vld_q;
  cws_pkg::coef_t                 rd_data_q;
  logic                           rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  // An entry never written reads as zero, which is its value after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== rtl/chebyshev_waveshaper_top.sv =====
// Top level of the Chebyshev polynomial waveshaper.
// A sample transfer starts a run that evaluates one polynomial term per clock, reading the
// coefficient table memory once per term while the recurrence produces the next Chebyshev
// value; the run is followed by a drain state and a finish state, in which the result is
// loaded into the output register once that register is free or being read. Only then is the
// next item taken. A coefficient write gives no result. The output register lets a new item
// be accepted while an earlier result still waits for its transfer.
`include "chebyshev_waveshaper_top_assert.svh"

module chebyshev_waveshaper_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [cws_pkg::CFG_W-1:0]  cfg_wdata_i,
  cws_in_if.sink                     in_i,
  cws_out_if.source                  out_o
);

  localparam int DW = cws_pkg::DATA_WIDTH;
  localparam int TW = cws_pkg::T_W;
  localparam int PW = cws_pkg::PROD_W;
  localparam int AW = cws_pkg::ACC_W;
  localparam int IW = cws_pkg::IDX_W;
  localparam int RW = DW + 3;
  localparam int YW = AW - cws_pkg::FRAC_C;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  localparam logic signed [TW-1:0] T_ONE     = TW'(1) << cws_pkg::FRAC_X;
  localparam logic signed [TW-1:0] T_NEG_ONE = -T_ONE;
  localparam logic signed [PW-1:0] REC_HALF  = PW'(1) << (cws_pkg::FRAC_X - 2);
  localparam logic signed [AW-1:0] ACC_HALF  = AW'(1) << (cws_pkg::FRAC_C - 1);
  localparam logic signed [DW-1:0] OUT_HI    = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] OUT_LO    = {1'b1, {(DW-1){1'b0}}};

  logic [1:0]              state_q, state_d;
  logic [IW-1:0]           k_q, k_d;
  logic [IW-1:0]           last_q, last_d;
  logic                    prod_vld_q;
  logic                    out_vld_q, out_vld_d;

  logic signed [DW-1:0]    x_q;
  logic signed [TW-1:0]    t_prev_q, t_cur_q;
  logic signed [PW-1:0]    prod_q;
  logic signed [AW-1:0]    acc_q;
  logic signed [DW-1:0]    out_smp_q;
  logic                    out_sat_q;

  logic                    in_acc, smp_start, load;
  cws_pkg::coef_wr_t       wr;
  logic [IW-1:0]           rd_addr;
  cws_pkg::coef_t          coef;

  logic signed [PW-1:0]    xt, xt_rnd, prod_d;
  logic signed [RW-1:0]    xt_sh, t_diff;
  logic signed [TW-1:0]    t_next;
  logic signed [AW-1:0]    acc_sum, acc_rnd;
  logic signed [YW-1:0]    y_wide;
  logic signed [DW-1:0]    y;
  logic                    y_sat;

  // Handshake and memory access.
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign smp_start  = in_acc && (in_i.action == cws_pkg::ACT_SAMPLE);

  assign wr.en   = in_acc && (in_i.action == cws_pkg::ACT_WRITE) &&
                   (int'(in_i.coeff_index) < cws_pkg::MAX_TERMS);
  assign wr.addr = IW'(in_i.coeff_index);
  assign wr.data = in_i.coeff_value;

  // The read for term k+1 is issued while term k is worked on; slot 0 is read at the start.
  assign rd_addr = (state_q == ST_RUN) ? k_q + IW'(1) : '0;

  cws_coef_mem u_coef_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (coef)
  );

  // Recurrence T(n+1) = 2x*T(n) - T(n-1), rounded half up and clamped to [-1, +1].
  assign xt     = x_q * t_cur_q;
  assign xt_rnd = xt + REC_HALF;
  assign xt_sh  = $signed(xt_rnd[PW-1:cws_pkg::FRAC_X-1]);
  assign t_diff = xt_sh - RW'(t_prev_q);

  always_comb begin
    if (t_diff > RW'(T_ONE)) begin
      t_next = T_ONE;
    end else if (t_diff < RW'(T_NEG_ONE)) begin
      t_next = T_NEG_ONE;
    end else begin
      t_next = $signed(t_diff[TW-1:0]);
    end
  end

  assign prod_d = coef * t_cur_q;

  // The accumulator is wide enough for every term sum, so it never overflows.
  assign acc_sum = acc_q + AW'(prod_q);
  assign acc_rnd = acc_q + ACC_HALF;
  assign y_wide  = $signed(acc_rnd[AW-1:cws_pkg::FRAC_C]);

  always_comb begin
    y_sat = 1'b0;
    if (y_wide > YW'(OUT_HI)) begin
      y     = OUT_HI;
      y_sat = 1'b1;
    end else if (y_wide < YW'(OUT_LO)) begin
      y     = OUT_LO;
      y_sat = 1'b1;
    end else begin
      y = $signed(y_wide[DW-1:0]);
    end
  end

  // Term count register, held as the index of the last term.
  always_comb begin
    last_d = last_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i < cws_pkg::CFG_W'(2)) begin
        last_d = IW'(1);
      end else if (int'(cfg_wdata_i) > cws_pkg::MAX_TERMS) begin
        last_d = IW'(cws_pkg::MAX_TERMS - 1);
      end else begin
        last_d = IW'(cfg_wdata_i - cws_pkg::CFG_W'(1));
      end
    end
  end

  assign load = (state_q == ST_FINISH) && (!out_vld_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    case (state_q)
      ST_IDLE: begin
        if (smp_start) begin
          state_d = ST_RUN;
          k_d     = '0;
        end
      end
      ST_RUN: begin
        if (k_q == last_q) begin
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + IW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      k_q        <= '0;
      last_q     <= IW'(1);
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      k_q        <= k_d;
      last_q     <= last_d;
      prod_vld_q <= (state_q == ST_RUN);
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_start) begin
      x_q      <= in_i.sample;
      t_prev_q <= T_ONE;
      t_cur_q  <= TW'(in_i.sample);
      acc_q    <= '0;
    end else begin
      if (state_q == ST_RUN) begin
        t_prev_q <= t_cur_q;
        t_cur_q  <= t_next;
      end
      if (prod_vld_q) begin
        acc_q <= acc_sum;
      end
    end
    if (state_q == ST_RUN) begin
      prod_q <= prod_d;
    end
    if (load) begin
      out_smp_q <= y;
      out_sat_q <= y_sat;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.shaped_sample = out_smp_q;
  assign out_o.saturated     = out_sat_q;

  `CWS_ASSERT_NEXT(a_start_runs, smp_start, state_q == ST_RUN)
  `CWS_ASSERT_IMPL(a_k_bound, state_q == ST_RUN, k_q <= last_q)
  `CWS_ASSERT_IMPL(a_t_range, state_q == ST_RUN, (t_cur_q <= T_ONE) && (t_cur_q >= T_NEG_ONE))
  `CWS_ASSERT_IMPL(a_prod_after_run, prod_vld_q, $past(state_q) == ST_RUN)
  `CWS_ASSERT_IMPL(a_terms_min, state_q == ST_RUN, last_q >= IW'(1))

endmodule
